### rtl/ptt_pkg.sv
// ---------------------------------------------------------------------------
// ptt_pkg: shared types for the page table translate block
// Entry layout, request modes, status codes and the per-request action.
// ---------------------------------------------------------------------------
package ptt_pkg;

   localparam int PHYS_W   = 8;
   localparam int VIRT_W   = 10;
   localparam int TOTAL_W  = 9;
   localparam int MAPPED_W = 10;
   localparam int FAULT_W  = 16;

   typedef enum logic [1:0] {
      MODE_MAP       = 2'd0,
      MODE_UNMAP     = 2'd1,
      MODE_TRANSLATE = 2'd2,
      MODE_WR_CHECK  = 2'd3
   } mode_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_INVALID    = 2'd1;
   localparam status_type ST_NOT_MAPPED = 2'd2;
   localparam status_type ST_READ_ONLY  = 2'd3;

   typedef struct packed {
      logic [PHYS_W-1:0] phys;
      logic              present;
      logic              writable;
      logic              user;
   } entry_type;

   localparam entry_type ENTRY_EMPTY = '0;

   // what one request does to the table and the counters
   typedef struct packed {
      logic              wr_en;
      entry_type         wr_entry;
      status_type        status;
      logic [PHYS_W-1:0] phys_out;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              fault;
   } action_type;

endpackage

### rtl/page_table_translate.sv
// ---------------------------------------------------------------------------
// page_table_translate: single-level page table with permission bits
//
// Request beats on req_* carry a mode (tuser) and the page fields (tdata).
// Each request yields exactly one response beat on rsp_*, with the status in
// tuser and the result page and both counters in tdata.
// The table read is issued on the beat that accepts the request; the decode
// stage then decides and writes back the entry, and loads the response register.
// One request per cycle is sustained while responses are taken, set by the
// single read-modify-write on the table memory (a one-entry bypass covers
// back-to-back hits on the same page).
// After reset a sweep clears all VIRT_PAGES entries, one per cycle, and
// req_tready stays low until the sweep is done. csr_wr_data sets the
// number of physical pages a map may target (256 after reset), capped at PHYS_PAGES.
// When rsp_tready is low the response holds, one more request can sit in
// the decode stage, and then req_tready drops.
// ---------------------------------------------------------------------------
module page_table_translate
   import ptt_pkg::*;
#(
   parameter int VIRT_PAGES = 729,
   parameter int PHYS_PAGES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // vpage[9:0], ppage[17:10],
                                     // writable[18], user[19], zero pad
   input  logic [1:0]   req_tuser,   // mode[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // phys_out[7:0], mapped_total[17:8],
                                     // fault_total[33:18], zero pad
   output logic [1:0]   rsp_tuser,   // status[1:0]
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(VIRT_PAGES);
   localparam int CNT_W = $clog2(VIRT_PAGES + 1);

   logic [TOTAL_W-1:0] total_ff;
   logic               req_acc, advance, clear_busy;

   logic [VIRT_W-1:0]  req_vp;
   logic [PHYS_W-1:0]  req_pp;
   logic               req_in_range;
   logic [IDX_W-1:0]   req_idx;

   logic               s1_valid_ff;
   mode_type           s1_mode_ff;
   logic               s1_in_range_ff;
   logic               s1_pp_ok_ff;
   logic [PHYS_W-1:0]  s1_pp_ff;
   logic               s1_wr_ff;
   logic               s1_user_ff;
   logic [IDX_W-1:0]   s1_idx_ff;

   entry_type          rd_entry, cur_entry;
   logic               fwd_valid_ff;
   logic [IDX_W-1:0]   fwd_idx_ff;
   entry_type          fwd_entry_ff;

   action_type         act;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;

   logic               out_valid_ff;
   status_type         out_status_ff;
   logic [PHYS_W-1:0]  out_phys_ff;
   logic [MAPPED_W-1:0] out_mapped_ff;
   logic [FAULT_W-1:0] out_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_W'(256);
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

   // handshake
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_busy && (!s1_valid_ff || advance);
   assign req_acc    = req_tvalid && req_tready;

   assign req_vp       = req_tdata[9:0];
   assign req_pp       = req_tdata[17:10];
   assign req_in_range = 32'(req_vp) < VIRT_PAGES;
   assign req_idx      = req_in_range ? req_vp[IDX_W-1:0] : IDX_W'(VIRT_PAGES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_mode_ff     <= mode_type'(req_tuser);
         s1_in_range_ff <= req_in_range;
         s1_pp_ok_ff    <= ({1'b0, req_pp} < total_ff) && (32'(req_pp) < PHYS_PAGES);
         s1_pp_ff       <= req_pp;
         s1_wr_ff       <= req_tdata[18];
         s1_user_ff     <= req_tdata[19];
         s1_idx_ff      <= req_idx;
      end
   end

   ptt_table #(
      .DEPTH (VIRT_PAGES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_acc),
      .rd_idx     (req_idx),
      .rd_entry   (rd_entry),
      .wr_en      (advance && act.wr_en),
      .wr_idx     (s1_idx_ff),
      .wr_entry   (act.wr_entry),
      .clear_busy (clear_busy)
   );

   // last write bypass: covers a read taken on the same edge as the write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (advance && act.wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && act.wr_en) begin
         fwd_idx_ff   <= s1_idx_ff;
         fwd_entry_ff <= act.wr_entry;
      end
   end

   assign cur_entry = (fwd_valid_ff && fwd_idx_ff == s1_idx_ff) ? fwd_entry_ff : rd_entry;

   ptt_decide u_decide (
      .mode      (s1_mode_ff),
      .in_range  (s1_in_range_ff),
      .pp_ok     (s1_pp_ok_ff),
      .map_page  (s1_pp_ff),
      .writable  (s1_wr_ff),
      .user      (s1_user_ff),
      .entry     (cur_entry),
      .act       (act)
   );

   assign cnt_in   = cnt_ff + CNT_W'(act.cnt_inc) - CNT_W'(act.cnt_dec);
   assign fault_in = (act.fault && fault_ff != '1) ? fault_ff + 1'b1 : fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         fault_ff <= '0;
      end else if (advance) begin
         cnt_ff   <= cnt_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= act.status;
         out_phys_ff   <= act.phys_out;
         out_mapped_ff <= MAPPED_W'(cnt_in);
         out_fault_ff  <= fault_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {6'd0, out_fault_ff, out_mapped_ff, out_phys_ff};

`ifndef SYNTH
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("request accepted during table clear");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault counter decreased");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= VIRT_PAGES)
      else $error("present count above table depth");

   a_step_exclusive: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(act.cnt_inc && act.cnt_dec))
      else $error("present count stepped both ways");

   a_dec_needs_present: assert property (@(posedge clock) disable iff (reset)
      (advance && act.cnt_dec) |-> (cur_entry.present && cnt_ff != '0))
      else $error("unmap of an entry not counted as present");
`endif

endmodule

### rtl/ptt_table.sv
// ---------------------------------------------------------------------------
// ptt_table: page table entry memory
// One registered read port, one write port, and a clearing sweep after reset
// that zeroes every entry, one per cycle.
// ---------------------------------------------------------------------------
module ptt_table
   import ptt_pkg::*;
#(
   parameter int DEPTH = 729
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output entry_type                rd_entry,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  entry_type                wr_entry,
   output logic                     clear_busy
);

   localparam int IDX_W = $clog2(DEPTH);

   entry_type            mem [DEPTH];
   entry_type            rd_entry_ff;
   logic                 clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]     clr_idx_ff, clr_idx_in;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   entry_type            mem_wd;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         if (clr_idx_ff == IDX_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assign mem_we = clr_busy_ff | wr_en;
   assign mem_wa = clr_busy_ff ? clr_idx_ff : wr_idx;
   assign mem_wd = clr_busy_ff ? ENTRY_EMPTY : wr_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // read-before-write on a shared address; caller forwards
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
      end
   end

   assign rd_entry   = rd_entry_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### rtl/ptt_decide.sv
// ---------------------------------------------------------------------------
// ptt_decide: request decision logic
// From the mode, range checks and current entry, picks status, result page,
// the entry update and the counter steps.
// ---------------------------------------------------------------------------
module ptt_decide
   import ptt_pkg::*;
(
   input  mode_type          mode,
   input  logic              in_range,
   input  logic              pp_ok,
   input  logic [PHYS_W-1:0] map_page,
   input  logic              writable,
   input  logic              user,
   input  entry_type         entry,
   output action_type        act
);

   always_comb begin
      act          = '0;
      act.status   = ST_OK;
      act.wr_entry = ENTRY_EMPTY;
      unique case (mode)
         MODE_MAP: begin
            if (!in_range || !pp_ok) begin
               act.status = ST_INVALID;
            end else begin
               act.wr_en             = 1'b1;
               act.wr_entry.phys     = map_page;
               act.wr_entry.present  = 1'b1;
               act.wr_entry.writable = writable;
               act.wr_entry.user     = user;
               act.cnt_inc           = !entry.present;
               act.phys_out          = map_page;
            end
         end
         MODE_UNMAP: begin
            if (!in_range) begin
               act.status = ST_INVALID;
            end else if (!entry.present) begin
               act.status = ST_NOT_MAPPED;
               act.fault  = 1'b1;
            end else begin
               act.phys_out = entry.phys;
               act.wr_en    = 1'b1;
               act.cnt_dec  = 1'b1;
            end
         end
         MODE_TRANSLATE: begin
            if (!in_range) begin
               act.status = ST_INVALID;
            end else if (!entry.present) begin
               act.status = ST_NOT_MAPPED;
            end else begin
               act.phys_out = entry.phys;
            end
         end
         MODE_WR_CHECK: begin
            // out-of-range pages were already clamped to the last entry
            if (!entry.present) begin
               act.status = ST_NOT_MAPPED;
               act.fault  = 1'b1;
            end else if (!entry.writable) begin
               act.status = ST_READ_ONLY;
            end else begin
               act.phys_out = entry.phys;
            end
         end
         default: act.status = ST_INVALID;
      endcase
   end

endmodule

### sim/page_table_translate_test.sv
// ---------------------------------------------------------------------------
// page_table_translate_test: self-checking bench for the page table block
// Request beats come from a queue and go out through a clocked driver. Each
// accepted request is run through a local copy of the table, the counters
// and the physical page limit, and the predicted response is queued. A
// clocked monitor compares every response beat field by field with the
// oldest prediction. The run covers directed corner cases, random traffic
// mostly on a small hot set of pages under several limit settings and idle
// mixes, and a short burst of faults on freshly cleared pages.
// ---------------------------------------------------------------------------
module page_table_translate_test;
   import ptt_pkg::*;

   localparam int VIRT_PAGES = 729;
   localparam int PHYS_PAGES = 256;
   localparam int FAULT_MAX  = 65535;

   typedef struct packed {
      mode_type          mode;
      logic [VIRT_W-1:0] vpage;
      logic [PHYS_W-1:0] ppage;
      logic              writable;
      logic              user;
   } page_req_type;

   typedef struct packed {
      status_type          status;
      logic [PHYS_W-1:0]   phys_out;
      logic [MAPPED_W-1:0] mapped_total;
      logic [FAULT_W-1:0]  fault_total;
   } page_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // vpage[9:0], ppage[17:10],
                                  // writable[18], user[19], zero pad
   logic [1:0]  req_tuser = MODE_MAP;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // phys_out[7:0], mapped_total[17:8],
                                  // fault_total[33:18], zero pad
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;

   // local copy of the block state
   entry_type page_map [VIRT_PAGES];
   int        present_tally = 0;
   int        fault_tally = 0;
   int        phys_limit_reg = 256;

   page_req_type req_pending [$];
   page_rsp_type rsp_predicted [$];
   page_req_type req_current;
   logic      req_taken = 1'b0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        fail_count = 0;

   page_table_translate #(
      .VIRT_PAGES(VIRT_PAGES),
      .PHYS_PAGES(PHYS_PAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // applies one request to the local table and returns the response it gives
   function automatic page_rsp_type predict_translation(page_req_type r);
      page_rsp_type o;
      int      lim;
      int      slot;
      o = '0;
      o.status = ST_OK;
      lim = (phys_limit_reg < PHYS_PAGES) ? phys_limit_reg : PHYS_PAGES;
      case (r.mode)
         MODE_MAP: begin
            if (r.vpage >= VIRT_PAGES || r.ppage >= lim) begin
               o.status = ST_INVALID;
            end else begin
               if (!page_map[r.vpage].present) present_tally++;
               page_map[r.vpage] = {r.ppage, 1'b1, r.writable, r.user};
               o.phys_out = r.ppage;
            end
         end
         MODE_UNMAP: begin
            if (r.vpage >= VIRT_PAGES) begin
               o.status = ST_INVALID;
            end else if (!page_map[r.vpage].present) begin
               o.status = ST_NOT_MAPPED;
               if (fault_tally < FAULT_MAX) fault_tally++;
            end else begin
               o.phys_out = page_map[r.vpage].phys;
               page_map[r.vpage] = ENTRY_EMPTY;
               if (present_tally > 0) present_tally--;
            end
         end
         MODE_TRANSLATE: begin
            if (r.vpage >= VIRT_PAGES) o.status = ST_INVALID;
            else if (!page_map[r.vpage].present) o.status = ST_NOT_MAPPED;
            else o.phys_out = page_map[r.vpage].phys;
         end
         default: begin
            // write check clamps to the last entry instead of rejecting
            slot = (r.vpage >= VIRT_PAGES) ? VIRT_PAGES - 1 : int'(r.vpage);
            if (!page_map[slot].present) begin
               o.status = ST_NOT_MAPPED;
               if (fault_tally < FAULT_MAX) fault_tally++;
            end else if (!page_map[slot].writable) begin
               o.status = ST_READ_ONLY;
            end else begin
               o.phys_out = page_map[slot].phys;
            end
         end
      endcase
      o.mapped_total = present_tally[MAPPED_W-1:0];
      o.fault_total = fault_tally[FAULT_W-1:0];
      return o;
   endfunction

   // request side: acceptance and prediction at the rising edge
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (req_taken) rsp_predicted.push_back(predict_translation(req_current));
   end

   // request and response drive at the falling edge
   always @(negedge clock) begin
      if (req_tvalid && !req_taken) begin
         // hold the beat until it is taken
      end else if (req_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_current = req_pending.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= {4'b0, req_current.user, req_current.writable,
                       req_current.ppage, req_current.vpage};
         req_tuser <= req_current.mode;
      end else begin
         req_tvalid <= 1'b0;
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      page_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_predicted.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, got status %0d",
                     $time, rsp_tuser);
            fail_count++;
         end else begin
            want = rsp_predicted.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("phys_out", want.phys_out, rsp_tdata[7:0]);
            check_field("mapped_total", want.mapped_total, rsp_tdata[17:8]);
            check_field("fault_total", want.fault_total, rsp_tdata[33:18]);
         end
      end
   end

   task automatic add_req(input mode_type m, input int vp, input int pp,
                          input bit wr, input bit us);
      page_req_type r;
      r.mode = m;
      r.vpage = vp[VIRT_W-1:0];
      r.ppage = pp[PHYS_W-1:0];
      r.writable = wr;
      r.user = us;
      req_pending.push_back(r);
   endtask

   task automatic add_random_req();
      int       sel;
      int       vp;
      int       pp;
      int       lim;
      mode_type m;
      sel = $urandom_range(0, 99);
      m = (sel < 35) ? MODE_MAP : (sel < 55) ? MODE_UNMAP :
          (sel < 80) ? MODE_TRANSLATE : MODE_WR_CHECK;
      // mostly a small hot set so maps, unmaps and lookups hit each other
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         vp = $urandom_range(0, 15);
         if (vp == 15) vp = VIRT_PAGES - 1;
      end else if (sel < 8) begin
         vp = $urandom_range(0, VIRT_PAGES - 1);
      end else if (sel == 8) begin
         vp = $urandom_range(VIRT_PAGES, 1023);
      end else begin
         vp = $urandom_range(0, 1023);
      end
      lim = (phys_limit_reg < PHYS_PAGES) ? phys_limit_reg : PHYS_PAGES;
      sel = $urandom_range(0, 99);
      if (sel < 15 && lim > 0) pp = (sel < 8 || lim > 255) ? lim - 1 : lim;
      else if (sel < 70 && lim > 0) pp = $urandom_range(0, lim - 1);
      else pp = $urandom_range(0, 255);
      add_req(m, vp, pp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // wait until every request is taken and every response has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (req_pending.size() != 0 || req_tvalid || rsp_predicted.size() != 0);
   endtask

   task automatic write_phys_limit(input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[8:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phys_limit_reg = value;
   endtask

   task automatic run_segment(input int lim, input int count, input int send_pct,
                              input int recv_pct);
      wait_idle();
      write_phys_limit(lim);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) add_random_req();
   endtask

   initial begin
      int vp;
      foreach (page_map[i]) page_map[i] = ENTRY_EMPTY;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 45;
      write_phys_limit(256);
      add_req(MODE_TRANSLATE, 0, 0, 0, 0);          // absent, no fault
      add_req(MODE_UNMAP, 0, 0, 0, 0);              // absent, fault
      add_req(MODE_WR_CHECK, 1023, 0, 0, 0);        // clamped, absent, fault
      add_req(MODE_MAP, VIRT_PAGES, 0, 1, 1);       // out of range
      add_req(MODE_MAP, 1023, 255, 1, 1);
      add_req(MODE_MAP, 0, 255, 1, 1);
      add_req(MODE_MAP, VIRT_PAGES - 1, 0, 0, 0);
      add_req(MODE_MAP, VIRT_PAGES - 1, 170, 0, 1); // overwrite, count holds
      add_req(MODE_WR_CHECK, 1023, 0, 0, 0);        // clamped, read only
      add_req(MODE_WR_CHECK, VIRT_PAGES - 1, 0, 0, 0);
      add_req(MODE_WR_CHECK, 0, 0, 0, 0);
      add_req(MODE_TRANSLATE, 0, 0, 0, 0);
      add_req(MODE_TRANSLATE, VIRT_PAGES - 1, 0, 0, 0);
      add_req(MODE_TRANSLATE, VIRT_PAGES, 0, 0, 0);
      add_req(MODE_TRANSLATE, 1023, 0, 0, 0);
      add_req(MODE_UNMAP, 1023, 0, 0, 0);           // out of range, no fault
      add_req(MODE_UNMAP, 0, 0, 0, 0);
      add_req(MODE_UNMAP, 0, 0, 0, 0);
      add_req(MODE_MAP, 341, 85, 1, 0);
      add_req(MODE_MAP, 682, 170, 1, 1);
      add_req(MODE_WR_CHECK, 682, 0, 0, 0);
      add_req(MODE_MAP, 5, 17, 1, 0);               // same page back to back
      add_req(MODE_TRANSLATE, 5, 0, 0, 0);
      add_req(MODE_UNMAP, 5, 0, 0, 0);
      add_req(MODE_TRANSLATE, 5, 0, 0, 0);
      repeat (250) add_random_req();

      run_segment(100, 250, 7, 45);
      run_segment(0, 150, 45, 7);
      run_segment(511, 250, 45, 7);
      run_segment(1, 250, 0, 0);
      run_segment(200, 250, 0, 0);

      // fault burst: each group clears a page, then keeps faulting on it
      repeat (10) begin
         vp = $urandom_range(0, VIRT_PAGES - 1);
         add_req(MODE_UNMAP, vp, 0, 0, 0);
         repeat (4) begin
            if ($urandom_range(0, 1)) add_req(MODE_UNMAP, vp, 0, 0, 0);
            else add_req(MODE_WR_CHECK, vp, 0, 0, 0);
         end
      end
      repeat (100) add_random_req();

      wait_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### page_table_translate.f
rtl/ptt_pkg.sv
rtl/ptt_table.sv
rtl/ptt_decide.sv
rtl/page_table_translate.sv
sim/page_table_translate_test.sv
